FILE: src/pjd_pkg.sv
// Shared codes for the priority job dispatcher: event kinds and result status.
// No dependencies; imported by the dispatcher top level.
package pjd_pkg;

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DONE = 2'd1;
  localparam logic [1:0] MODE_DISP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NONE      = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  localparam int TAG_W = 8;
  localparam int RUN_W = 5;

endpackage

FILE: src/pjd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; used for the tag store and the per-level pointer table.
module pjd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/priority_job_dispatcher.sv
// Strict-priority job dispatcher on pjd_pkg and pjd_ram: per-level FIFOs in one tag RAM.
// Enqueue and completion give one result each; a dispatch selects the level, then for each
// job reads the pointer entry and then the tag (one ST_NONE result when nothing starts).
// The next beat is taken once a beat's last result is registered, later while results wait.
// Reset (rst, synchronous): clears running count, level-valid and non-empty bits, limit to 1.
// Tag RAM not cleared; pointer entries read as zero until first written. No clear pass.
module priority_job_dispatcher
  import pjd_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int MAX_SLOTS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // job_tag[7:0], priority_req[10:8], zero fill
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // dispatched_tag[7:0], status[9:8], running_now[14:10]
  output logic        m_axis_tuser,   // dispatch_valid
  output logic        m_axis_tlast    // last
);

  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int HW    = $clog2(LEVEL_DEPTH);
  localparam int CNTW  = $clog2(LEVEL_DEPTH + 1);
  localparam int QDEP  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int QAW   = $clog2(QDEP);
  localparam int LEW   = 2 * HW + CNTW;
  localparam int RW    = $clog2(MAX_SLOTS + 1);
  localparam int CW    = (RW > RUN_W) ? RW : RUN_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ENQ  = 6'b000010,
    S_DONE = 6'b000100,
    S_DSEL = 6'b001000,
    S_DLVL = 6'b010000,
    S_DTAG = 6'b100000
  } state_t;

  typedef struct packed {
    logic [CNTW-1:0] count;
    logic [HW-1:0]   tail;
    logic [HW-1:0]   head;
  } level_ent_t;

  state_t state, state_next;

  logic [4:0]            max_running;
  logic [CW-1:0]         running, running_next;
  logic [NUM_LEVELS-1:0] nonempty, nonempty_next;
  logic [NUM_LEVELS-1:0] lvl_valid, lvl_valid_next;
  logic [LW-1:0]         cur_lvl, cur_lvl_next;
  logic [QAW-1:0]        qa, qa_next;
  logic [TAG_W-1:0]      tag_r;

  logic             o_valid;
  logic [TAG_W-1:0] o_tag;
  logic             o_dv;
  logic             o_last;
  logic [1:0]       o_status;
  logic [RUN_W-1:0] o_run;

  logic             emit;
  logic [TAG_W-1:0] e_tag;
  logic             e_dv;
  logic             e_last;
  logic [1:0]       e_status;

  logic             accept, out_ok, can_go;
  logic [5:0]       prio_w;
  logic [LW-1:0]    in_lvl, found;
  logic [CW-1:0]    limit, mr_ext;
  level_ent_t       ent, l_wdata;
  logic [LEW-1:0]   l_rdata;
  logic             l_we, q_we;
  logic [LW-1:0]    l_raddr;
  logic [QAW-1:0]   q_waddr, q_raddr, q_rd_comb;
  logic [TAG_W-1:0] q_rdata;

  function automatic logic [HW-1:0] adv(input logic [HW-1:0] p);
    return (p == HW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [LW-1:0] l, input logic [HW-1:0] p);
    return QAW'(QAW'(l) * QAW'(LEVEL_DEPTH)) + QAW'(p);
  endfunction

  pjd_ram #(.WIDTH(TAG_W), .DEPTH(QDEP)) u_tag_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (tag_r),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  pjd_ram #(.WIDTH(LEW), .DEPTH(NUM_LEVELS)) u_level_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (cur_lvl),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_ok        = !o_valid || m_axis_tready;

  // Saturate the requested level to the top level.
  assign prio_w = {3'b000, s_axis_tdata[10:8]};
  assign in_lvl = (prio_w >= 6'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1) : prio_w[LW-1:0];

  assign mr_ext = CW'(max_running);
  assign limit  = (mr_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : mr_ext;
  assign can_go = (running < limit) && (|nonempty);

  // Highest non-empty level.
  always_comb begin
    found = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i]) begin
        found = LW'(i);
      end
    end
  end

  // A pointer entry never written reads as zero.
  assign ent       = lvl_valid[cur_lvl] ? level_ent_t'(l_rdata) : '0;
  assign q_waddr   = qaddr(cur_lvl, ent.tail);
  assign q_rd_comb = qaddr(cur_lvl, ent.head);

  always_comb begin
    state_next     = state;
    running_next   = running;
    nonempty_next  = nonempty;
    lvl_valid_next = lvl_valid;
    cur_lvl_next   = cur_lvl;
    qa_next        = qa;
    l_raddr        = cur_lvl;
    q_raddr        = qa;
    l_we           = 1'b0;
    l_wdata        = ent;
    q_we           = 1'b0;
    emit           = 1'b0;
    e_tag          = '0;
    e_dv           = 1'b0;
    e_last         = 1'b1;
    e_status       = ST_OK;
    case (state)
      S_IDLE: begin
        l_raddr = in_lvl;
        if (accept) begin
          cur_lvl_next = in_lvl;
          case (s_axis_tuser)
            MODE_ENQ:  state_next = S_ENQ;
            MODE_DONE: state_next = S_DONE;
            MODE_DISP: state_next = S_DSEL;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ENQ: begin
        if (out_ok) begin
          emit = 1'b1;
          if (ent.count >= CNTW'(LEVEL_DEPTH)) begin
            e_status = ST_FULL;
          end else begin
            q_we                    = 1'b1;
            l_we                    = 1'b1;
            l_wdata.tail            = adv(ent.tail);
            l_wdata.count           = ent.count + 1'b1;
            lvl_valid_next[cur_lvl] = 1'b1;
            nonempty_next[cur_lvl]  = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_ok) begin
          emit = 1'b1;
          if (running == '0) begin
            e_status = ST_UNDERFLOW;
          end else begin
            running_next = running - 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_DSEL: begin
        l_raddr = found;
        if (can_go) begin
          cur_lvl_next = found;
          state_next   = S_DLVL;
        end else if (out_ok) begin
          emit       = 1'b1;
          e_status   = ST_NONE;
          state_next = S_IDLE;
        end
      end
      S_DLVL: begin
        // Pop the head: fetch its tag, advance the pointer, count the job as running.
        q_raddr                 = q_rd_comb;
        qa_next                 = q_rd_comb;
        l_we                    = 1'b1;
        l_wdata.head            = adv(ent.head);
        l_wdata.count           = ent.count - 1'b1;
        lvl_valid_next[cur_lvl] = 1'b1;
        nonempty_next[cur_lvl]  = (ent.count != CNTW'(1));
        running_next            = running + 1'b1;
        state_next              = S_DTAG;
      end
      S_DTAG: begin
        l_raddr = found;
        if (out_ok) begin
          emit   = 1'b1;
          e_tag  = q_rdata;
          e_dv   = 1'b1;
          e_last = !can_go;
          if (can_go) begin
            cur_lvl_next = found;
            state_next   = S_DLVL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_running <= 5'd1;
      running     <= '0;
      nonempty    <= '0;
      lvl_valid   <= '0;
      o_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      running   <= running_next;
      nonempty  <= nonempty_next;
      lvl_valid <= lvl_valid_next;
      if (cfg_wr_en) begin
        max_running <= cfg_wr_data;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_lvl <= cur_lvl_next;
    qa      <= qa_next;
    if (accept) begin
      tag_r <= s_axis_tdata[7:0];
    end
    if (emit) begin
      o_tag    <= e_tag;
      o_dv     <= e_dv;
      o_last   <= e_last;
      o_status <= e_status;
      o_run    <= running_next[RUN_W-1:0];
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {1'b0, o_run, o_status, o_tag};
  assign m_axis_tuser  = o_dv;
  assign m_axis_tlast  = o_last;

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    running <= CW'(MAX_SLOTS))
    else $error("running count above slot count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DLVL) |-> (ent.count != '0))
    else $error("pop from an empty level");

  a_dispatch_ok: assert property (@(posedge clk) disable iff (rst)
    (emit && e_dv) |=> (o_status == ST_OK && o_valid))
    else $error("dispatched job with error status");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !m_axis_tready) |-> !emit)
    else $error("result overwritten while waiting");

endmodule
